// ===== sv/ipv4_udp_encap_header_builder_macros.svh =====
// Assertion macros shared by the header builder RTL.
// Expects clk and rst_n in scope at the point of use.
`ifndef IPV4_UDP_ENCAP_HEADER_BUILDER_MACROS_SVH
`define IPV4_UDP_ENCAP_HEADER_BUILDER_MACROS_SVH

// Clocked property, ignored while in reset.
`define IUEHB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge.
`define IUEHB_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== sv/iuehb_pkg.sv =====
// Package for the IPv4/UDP header builder: constants, header record and queue status.
// No dependencies.
package iuehb_pkg;

    localparam logic [7:0]  IPV4_VER_IHL    = 8'h45;
    localparam logic [7:0]  IPV4_TOS        = 8'h00;
    localparam logic [7:0]  IPV4_PROTO_UDP  = 8'h11;
    localparam logic [7:0]  TTL_RESET       = 8'd64;
    localparam logic [16:0] TOTAL_HDR_BYTES = 17'd28;
    localparam logic [15:0] UDP_HDR_BYTES   = 16'd8;
    localparam logic [15:0] HALF_ZERO       = 16'h0000;
    localparam int          QUEUE_DEPTH_DEF = 2;

    // Header word positions
    localparam logic [2:0] WORD_VER_LEN  = 3'd0;
    localparam logic [2:0] WORD_IDENT    = 3'd1;
    localparam logic [2:0] WORD_TTL_CSUM = 3'd2;
    localparam logic [2:0] WORD_SADDR    = 3'd3;
    localparam logic [2:0] WORD_DADDR    = 3'd4;
    localparam logic [2:0] WORD_PORTS    = 3'd5;
    localparam logic [2:0] WORD_UDP_LEN  = 3'd6;
    localparam logic [2:0] WORD_LAST     = WORD_UDP_LEN;

    typedef struct packed {
        logic [15:0] ip_ident;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [15:0] total_len;
        logic [15:0] udp_len;
        logic [7:0]  ttl;
        logic [15:0] checksum;
        logic        wrapped;
    } hdr_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== sv/iuehb_front.sv =====
// Front end: takes requests, holds TTL, works out lengths and the IPv4 checksum.
// Depends on iuehb_pkg.
module iuehb_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [7:0]           cfg_wdata,
    input  logic                 start,
    output logic                 busy,
    input  logic [15:0]          ip_ident,
    input  logic [31:0]          source_address,
    input  logic [31:0]          dest_address,
    input  logic [15:0]          source_port,
    input  logic [15:0]          dest_port,
    input  logic [15:0]          payload_bytes,
    input  iuehb_pkg::q_status_t q_status,
    output logic                 push,
    output iuehb_pkg::hdr_rec_t  push_rec
);
    import iuehb_pkg::*;

    logic [7:0]  ttl_reg;
    logic        s_valid_reg;
    logic        s_valid_next;
    hdr_rec_t    s_rec_reg;
    logic [17:0] addr_sum_reg;
    logic        accept;
    logic [16:0] total_full;
    logic [18:0] hdr_sum;
    logic [16:0] fold1;
    logic [15:0] fold2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ttl_reg <= TTL_RESET;
        end
        else if (cfg_we)
        begin
            ttl_reg <= cfg_wdata;
        end
    end

    assign busy   = s_valid_reg & q_status.full;
    assign accept = start & ~busy;
    assign push   = s_valid_reg & ~q_status.full;

    assign total_full = {1'b0, payload_bytes} + TOTAL_HDR_BYTES;

    always_comb
    begin
        s_valid_next = s_valid_reg;
        if (accept)
        begin
            s_valid_next = 1'b1;
        end
        else if (push)
        begin
            s_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
        end
        else
        begin
            s_valid_reg <= s_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s_rec_reg.ip_ident       <= ip_ident;
            s_rec_reg.source_address <= source_address;
            s_rec_reg.dest_address   <= dest_address;
            s_rec_reg.source_port    <= source_port;
            s_rec_reg.dest_port      <= dest_port;
            s_rec_reg.total_len      <= total_full[15:0];
            s_rec_reg.udp_len        <= payload_bytes + UDP_HDR_BYTES;
            s_rec_reg.ttl            <= ttl_reg;
            s_rec_reg.checksum       <= HALF_ZERO;
            s_rec_reg.wrapped        <= total_full[16];
            addr_sum_reg <= {2'b00, source_address[31:16]} + {2'b00, source_address[15:0]}
                          + {2'b00, dest_address[31:16]} + {2'b00, dest_address[15:0]};
        end
    end

    // Remaining halfwords, then ones'-complement fold
    assign hdr_sum = {1'b0, addr_sum_reg}
                   + {3'b000, IPV4_VER_IHL, IPV4_TOS}
                   + {3'b000, s_rec_reg.total_len}
                   + {3'b000, s_rec_reg.ip_ident}
                   + {3'b000, s_rec_reg.ttl, IPV4_PROTO_UDP};
    assign fold1 = {14'd0, hdr_sum[18:16]} + {1'b0, hdr_sum[15:0]};
    assign fold2 = fold1[15:0] + {15'd0, fold1[16]};

    always_comb
    begin
        push_rec          = s_rec_reg;
        push_rec.checksum = ~fold2;
    end

endmodule

// ===== sv/iuehb_fifo.sv =====
// Short queue of header records between front and back.
// Depends on iuehb_pkg and the assertion macro header.
module iuehb_fifo #(
    parameter int DEPTH = iuehb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  iuehb_pkg::hdr_rec_t  push_rec,
    input  logic                 pop,
    output iuehb_pkg::hdr_rec_t  head_rec,
    output iuehb_pkg::q_status_t status
);
    import iuehb_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    hdr_rec_t      mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

    assign head_rec     = mem[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

`include "ipv4_udp_encap_header_builder_macros.svh"

    `IUEHB_NEVER(a_no_push_full, push && status.full, "push into full queue")
    `IUEHB_NEVER(a_no_pop_empty, pop && status.empty, "pop from empty queue")

endmodule

// ===== sv/iuehb_back.sv =====
// Back end: serialises one header record as seven registered 32-bit words.
// Depends on iuehb_pkg and the assertion macro header.
module iuehb_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  iuehb_pkg::q_status_t q_status,
    input  iuehb_pkg::hdr_rec_t  head_rec,
    output logic                 pop,
    output logic                 strobe,
    output logic [2:0]           word_index,
    output logic [31:0]          header_word,
    output logic                 last_word,
    output logic                 length_wrapped
);
    import iuehb_pkg::*;

    hdr_rec_t    rec_reg;
    logic        active_reg;
    logic        active_next;
    logic [2:0]  cnt_reg;
    logic [2:0]  cnt_next;
    logic        strobe_reg;
    logic [2:0]  index_reg;
    logic [31:0] word_reg;
    logic [31:0] word_next;
    logic        last_reg;
    logic        wrapped_reg;
    logic        at_last;

    assign at_last = (cnt_reg == WORD_LAST);
    assign pop     = ~q_status.empty & (~active_reg | at_last);

    always_comb
    begin
        active_next = active_reg;
        cnt_next    = cnt_reg;
        if (pop)
        begin
            active_next = 1'b1;
            cnt_next    = WORD_VER_LEN;
        end
        else if (active_reg)
        begin
            active_next = ~at_last;
            cnt_next    = cnt_reg + 3'd1;
        end
    end

    always_comb
    begin
        case (cnt_reg)
            WORD_VER_LEN:  word_next = {IPV4_VER_IHL, IPV4_TOS, rec_reg.total_len};
            WORD_IDENT:    word_next = {rec_reg.ip_ident, HALF_ZERO};
            WORD_TTL_CSUM: word_next = {rec_reg.ttl, IPV4_PROTO_UDP, rec_reg.checksum};
            WORD_SADDR:    word_next = rec_reg.source_address;
            WORD_DADDR:    word_next = rec_reg.dest_address;
            WORD_PORTS:    word_next = {rec_reg.source_port, rec_reg.dest_port};
            WORD_UDP_LEN:  word_next = {rec_reg.udp_len, HALF_ZERO};
            default:       word_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= WORD_VER_LEN;
            strobe_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            cnt_reg    <= cnt_next;
            strobe_reg <= active_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rec_reg <= head_rec;
        end
        if (active_reg)
        begin
            index_reg   <= cnt_reg;
            word_reg    <= word_next;
            last_reg    <= at_last;
            wrapped_reg <= rec_reg.wrapped;
        end
    end

    assign strobe         = strobe_reg;
    assign word_index     = index_reg;
    assign header_word    = word_reg;
    assign last_word      = last_reg;
    assign length_wrapped = wrapped_reg;

`include "ipv4_udp_encap_header_builder_macros.svh"

    `IUEHB_ASSERT(a_last_on_final, strobe && last_word |-> word_index == WORD_LAST, "last flag off final word")
    `IUEHB_ASSERT(a_words_in_run, strobe && !last_word |=> strobe && word_index == $past(word_index) + 3'd1, "gap or skip inside a header")

endmodule

// ===== sv/ipv4_udp_encap_header_builder.sv =====
// IPv4/UDP encapsulation header builder, top level.
// Depends on iuehb_pkg, iuehb_front, iuehb_fifo and iuehb_back.
//
// A request is taken when start is high and busy is low. Each request gives seven
// 32-bit header words, one per cycle on strobe, word_index 0 to 6, with last_word
// on the seventh; the receiver cannot stall them. A taken request passes the front
// register, the queue and the back end's record register before its words go out;
// the single word-per-cycle output serialiser sets the sustained request rate. A queue of
// QUEUE_DEPTH records plus one front register lets up to that many further
// requests be taken while a header is still going out; busy rises once they fill.
// cfg_we writes the TTL from cfg_wdata (reset 64); write it only while idle.
module ipv4_udp_encap_header_builder #(
    parameter int QUEUE_DEPTH = iuehb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] ip_ident,
    input  logic [31:0] source_address,
    input  logic [31:0] dest_address,
    input  logic [15:0] source_port,
    input  logic [15:0] dest_port,
    input  logic [15:0] payload_bytes,
    output logic        strobe,
    output logic [2:0]  word_index,
    output logic [31:0] header_word,
    output logic        last_word,
    output logic        length_wrapped
);
    import iuehb_pkg::*;

    q_status_t q_status;
    hdr_rec_t  push_rec;
    hdr_rec_t  head_rec;
    logic      push;
    logic      pop;

    iuehb_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .start          (start),
        .busy           (busy),
        .ip_ident       (ip_ident),
        .source_address (source_address),
        .dest_address   (dest_address),
        .source_port    (source_port),
        .dest_port      (dest_port),
        .payload_bytes  (payload_bytes),
        .q_status       (q_status),
        .push           (push),
        .push_rec       (push_rec)
    );

    iuehb_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head_rec (head_rec),
        .status   (q_status)
    );

    iuehb_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_status       (q_status),
        .head_rec       (head_rec),
        .pop            (pop),
        .strobe         (strobe),
        .word_index     (word_index),
        .header_word    (header_word),
        .last_word      (last_word),
        .length_wrapped (length_wrapped)
    );

endmodule

// ===== tb/tb.sv =====
// Testbench for ipv4_udp_encap_header_builder: random and directed header requests.
// A scoreboard class predicts the seven header words of each request and checks them.
// Depends on iuehb_pkg and the header builder RTL.
module tb;
    import iuehb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [15:0] ip_ident;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [15:0] payload_bytes;
    } encap_request_t;

    typedef struct packed {
        logic [2:0]  word_index;
        logic [31:0] header_word;
        logic        last_word;
        logic        length_wrapped;
    } header_beat_t;

    class header_scoreboard;
        logic [7:0]   time_to_live;
        header_beat_t expected_beats[$];
        int           errors;
        int           words_seen;

        function new();
            time_to_live = TTL_RESET;
            errors = 0;
            words_seen = 0;
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        function void note_request(encap_request_t r);
            logic [31:0]  w[7];
            logic [16:0]  total;
            logic [15:0]  udp_len;
            int unsigned  sum;
            header_beat_t b;
            int k;
            total = TOTAL_HDR_BYTES + {1'b0, r.payload_bytes};
            udp_len = UDP_HDR_BYTES + r.payload_bytes;
            w[0] = {IPV4_VER_IHL, IPV4_TOS, total[15:0]};
            w[1] = {r.ip_ident, HALF_ZERO};
            w[2] = {time_to_live, IPV4_PROTO_UDP, HALF_ZERO};
            w[3] = r.source_address;
            w[4] = r.dest_address;
            sum = 0;
            for (k = 0; k < 5; k++)
                sum += w[k][31:16] + w[k][15:0];
            sum = (sum >> 16) + (sum & 32'hFFFF);
            sum = sum + (sum >> 16);
            w[2][15:0] = ~sum[15:0];
            w[5] = {r.source_port, r.dest_port};
            w[6] = {udp_len, HALF_ZERO};
            for (k = 0; k < 7; k++)
            begin
                b.word_index = k[2:0];
                b.header_word = w[k];
                b.last_word = (k[2:0] == WORD_LAST);
                b.length_wrapped = total[16];
                expected_beats = {expected_beats, b};
            end
        endfunction

        task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
            $display("mismatch on %s at word %0d: got %h, want %h",
                     field, words_seen, got, want);
            errors++;
        endtask

        task check_beat(header_beat_t got);
            header_beat_t want;
            if (expected_beats.size() == 0)
            begin
                report_mismatch("unexpected word", got.header_word, 32'h0);
            end
            else
            begin
                want = expected_beats.pop_front();
                if (got.word_index !== want.word_index)
                    report_mismatch("word_index", 32'(got.word_index),
                                    32'(want.word_index));
                if (got.header_word !== want.header_word)
                    report_mismatch("header_word", got.header_word, want.header_word);
                if (got.last_word !== want.last_word)
                    report_mismatch("last_word", 32'(got.last_word),
                                    32'(want.last_word));
                if (got.length_wrapped !== want.length_wrapped)
                    report_mismatch("length_wrapped", 32'(got.length_wrapped),
                                    32'(want.length_wrapped));
            end
            words_seen++;
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;
    logic        start;
    logic        busy;
    logic [15:0] ip_ident;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] payload_bytes;
    logic        strobe;
    logic [2:0]  word_index;
    logic [31:0] header_word;
    logic        last_word;
    logic        length_wrapped;

    header_scoreboard sb;
    int cycles;

    ipv4_udp_encap_header_builder uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .start          (start),
        .busy           (busy),
        .ip_ident       (ip_ident),
        .source_address (source_address),
        .dest_address   (dest_address),
        .source_port    (source_port),
        .dest_port      (dest_port),
        .payload_bytes  (payload_bytes),
        .strobe         (strobe),
        .word_index     (word_index),
        .header_word    (header_word),
        .last_word      (last_word),
        .length_wrapped (length_wrapped)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial sb = new();

    // request transfer on start && !busy, one header word per strobe
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            sb.note_request({ip_ident, source_address, dest_address,
                             source_port, dest_port, payload_bytes});
        if (rst_n && strobe)
            sb.check_beat({word_index, header_word, last_word, length_wrapped});
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic encap_request_t make_req(logic [15:0] ident, logic [31:0] saddr,
                                                logic [31:0] daddr, logic [15:0] sport,
                                                logic [15:0] dport, logic [15:0] pay);
        encap_request_t r;
        r = {ident, saddr, daddr, sport, dport, pay};
        return r;
    endfunction

    function automatic encap_request_t random_req();
        encap_request_t r;
        r.ip_ident = 16'($urandom_range(16'hFFFF));
        r.source_address = $urandom();
        r.dest_address = $urandom();
        r.source_port = 16'($urandom_range(16'hFFFF));
        r.dest_port = 16'($urandom_range(16'hFFFF));
        case ($urandom_range(9))
            0: r.payload_bytes = 16'($urandom_range(16'hFFFF, 16'hFFD0));
            1: r.payload_bytes = 16'($urandom_range(64));
            default: r.payload_bytes = 16'($urandom_range(16'hFFFF));
        endcase
        return r;
    endfunction

    function automatic int idle_gap(int pct);
        int g;
        g = 0;
        while (g < 40 && $urandom_range(99) < pct)
            g++;
        return g;
    endfunction

    task automatic send_request(encap_request_t r, int idle_pct);
        int gap;
        gap = idle_gap(idle_pct);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        ip_ident <= r.ip_ident;
        source_address <= r.source_address;
        dest_address <= r.dest_address;
        source_port <= r.source_port;
        dest_port <= r.dest_port;
        payload_bytes <= r.payload_bytes;
        do @(posedge clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_ttl(logic [7:0] value);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.time_to_live = value;
    endtask

    task automatic random_phase(int count, int idle_pct);
        for (int i = 0; i < count; i++)
            send_request(random_req(), idle_pct);
    endtask

    initial
    begin
        int mode_pct;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= 8'h00;
        start <= 1'b0;
        ip_ident <= 16'h0;
        source_address <= 32'h0;
        dest_address <= 32'h0;
        source_port <= 16'h0;
        dest_port <= 16'h0;
        payload_bytes <= 16'h0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset TTL; length boundaries and a header whose checksum folds to zero
        send_request(make_req(16'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'd0), 0);
        send_request(make_req(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                              16'hFFFF, 16'hFFFF), 0);
        send_request(make_req(16'h1234, 32'hC0A8_0001, 32'h0A00_0001, 16'd53,
                              16'd4789, 16'd65507), 0);
        send_request(make_req(16'h1235, 32'hC0A8_0001, 32'h0A00_0001, 16'd53,
                              16'd4789, 16'd65508), 0);
        send_request(make_req(16'h0001, 32'h7F00_0001, 32'h7F00_0001, 16'h8000,
                              16'h0001, 16'd65527), 0);
        send_request(make_req(16'h8000, 32'h0102_0304, 32'h0506_0708, 16'h0001,
                              16'h8000, 16'd65528), 0);
        send_request(make_req(16'h0, 32'h7AD2_0000, 32'h0, 16'h0, 16'h0, 16'd0), 0);
        send_request(make_req(16'hAAAA, 32'hAAAA_AAAA, 32'h5555_5555, 16'h5555,
                              16'hAAAA, 16'h5555), 0);
        send_request(make_req(16'h5555, 32'h5555_5555, 32'hAAAA_AAAA, 16'hAAAA,
                              16'h5555, 16'hAAAA), 3);
        send_request(make_req(16'hFFFF, 32'h8000_0000, 32'h0000_0001, 16'hFFFF,
                              16'h0000, 16'd1), 0);

        write_ttl(8'h00);
        send_request(make_req(16'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'd0), 0);
        send_request(make_req(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                              16'hFFFF, 16'hFFFF), 0);
        random_phase(110, 0);

        write_ttl(8'hFF);
        send_request(make_req(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                              16'hFFFF, 16'hFFFF), 0);
        random_phase(110, 77);

        write_ttl(8'($urandom_range(8'hFF)));
        random_phase(110, 24);

        write_ttl(8'($urandom_range(8'hFF)));
        mode_pct = 0;
        for (int i = 0; i < 110; i++)
        begin
            if (i % 20 == 0)
                case ($urandom_range(2))
                    0: mode_pct = 0;
                    1: mode_pct = 77;
                    default: mode_pct = 24;
                endcase
            send_request(random_req(), mode_pct);
        end

        drain();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
